/* rtl/circular_deque_assert.svh */
// ----------------------------------------------------------------------------
// circular_deque_assert.svh
// Assertion macros for the deque block; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define CDQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular_deque: assertion failed");
// Next-cycle implication, disabled while reset is low
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular_deque: assertion failed");
`else
`define CDQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes of the deque block.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Operation codes of an input item
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Classified command handed from the front end to the execution unit
  typedef struct packed {
    logic              is_push;
    logic              at_front;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // One result item
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
    logic [OCC_W-1:0]  occupancy;
    logic              empty_flag;
    logic              full_flag;
  } res_t;

endpackage

/* rtl/cdq_in_if.sv */
// ----------------------------------------------------------------------------
// cdq_in_if
// Request channel of the deque: valid/ready with operation and push value.
// ----------------------------------------------------------------------------
interface cdq_in_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

/* rtl/cdq_out_if.sv */
// ----------------------------------------------------------------------------
// cdq_out_if
// Result channel of the deque: valid/ready with status and state snapshot.
// ----------------------------------------------------------------------------
interface cdq_out_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [OCC_W-1:0]         occupancy;
  logic                     empty_flag;
  logic                     full_flag;

  modport source (output valid, output status, output front_value, output back_value,
                  output occupancy, output empty_flag, output full_flag, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input occupancy, input empty_flag, input full_flag, output ready);
endinterface

/* rtl/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH 32-bit entries held in a ring in RAM.
// Requests arrive on in_i (kind, push_value); each yields exactly one result
// on out_o with the status and the state left behind: front and back entry
// (zero when empty), occupancy, empty and full flags. A push into a full
// deque or a pop from an empty one reports a reject status, changes nothing.
// A two-entry command queue decouples request intake from execution.
// A result passes the command queue and the output register; a pop that
// leaves entries behind also passes the S_READ state, since the new end is
// read from the entry RAM through its registered read port.
// Throughput: one item per cycle for pushes and rejected operations while
// the receiver is ready; a pop leaving entries stalls intake for its RAM read.
// Reset clears indices, count and handshake state at once; RAM contents
// stay undefined and are never read before written. When the receiver
// stalls, the result is held in the output register, the command queue
// fills and in_i.ready drops after two more requests.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);
  import cdq_pkg::*;

  `include "circular_deque_assert.svh"

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic res_valid;
  res_t res;

  cdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  cdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (out_o.ready)
  );

  // Drive the result channel
  assign out_o.valid       = res_valid;
  assign out_o.status      = res.status;
  assign out_o.front_value = res.front_value;
  assign out_o.back_value  = res.back_value;
  assign out_o.occupancy   = res.occupancy;
  assign out_o.empty_flag  = res.empty_flag;
  assign out_o.full_flag   = res.full_flag;

  // An empty deque reports zero values and zero occupancy
  `CDQ_ASSERT_IMPLY(a_empty_zero, clk_i, rst_ni, out_o.valid && out_o.empty_flag,
    out_o.front_value == '0 && out_o.back_value == '0 && out_o.occupancy == '0)
  // A full reject leaves the deque full
  `CDQ_ASSERT_IMPLY(a_full_reject, clk_i, rst_ni,
    out_o.valid && out_o.status == STATUS_FULL, out_o.full_flag && !out_o.empty_flag)
  // An empty reject leaves the deque empty
  `CDQ_ASSERT_IMPLY(a_empty_reject, clk_i, rst_ni,
    out_o.valid && out_o.status == STATUS_EMPTY, out_o.empty_flag && !out_o.full_flag)
  // A push taken by the executor presents its result in the next cycle
  `CDQ_ASSERT_NEXT(a_res_follows, clk_i, rst_ni,
    cmd_valid && cmd_ready && cmd.is_push, out_o.valid)

endmodule

/* rtl/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cdq_front.sv */
// ----------------------------------------------------------------------------
// cdq_front
// Request front end: decodes each operation and buffers it in a two-entry
// command queue ahead of the execution unit.
// ----------------------------------------------------------------------------
module cdq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  cdq_in_if.sink        in_i,
  output logic          cmd_valid_o,
  output cdq_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);
  import cdq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  cmd_t              in_cmd;
  logic              push, pop;

  // Classify the incoming operation
  always_comb begin
    in_cmd.value = in_i.push_value;
    unique case (kind_e'(in_i.kind))
      KIND_PUSH_FRONT: begin in_cmd.is_push = 1'b1; in_cmd.at_front = 1'b1; end
      KIND_PUSH_BACK:  begin in_cmd.is_push = 1'b1; in_cmd.at_front = 1'b0; end
      KIND_POP_FRONT:  begin in_cmd.is_push = 1'b0; in_cmd.at_front = 1'b1; end
      KIND_POP_BACK:   begin in_cmd.is_push = 1'b0; in_cmd.at_front = 1'b0; end
      default:         begin in_cmd.is_push = 1'b0; in_cmd.at_front = 1'b0; end
    endcase
  end

  assign in_i.ready  = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the command on transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

/* rtl/cdq_back.sv */
// ----------------------------------------------------------------------------
// cdq_back
// Execution unit: keeps the ring indices, the entry count and copies of the
// front and back entries; writes pushes to the entry RAM and reads the
// newly exposed end after a pop that leaves entries. Results leave through an output register.
// ----------------------------------------------------------------------------
module cdq_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cdq_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          res_valid_o,
  output cdq_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import cdq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic S_RUN  = 1'b0;
  localparam logic S_READ = 1'b1;

  logic              state_q, state_d;
  logic [IW-1:0]     front_idx_q, front_idx_d;
  logic [IW-1:0]     back_idx_q, back_idx_d;
  logic [CW-1:0]     count_q, count_d;
  logic [DATA_W-1:0] front_val_q, front_val_d;
  logic [DATA_W-1:0] back_val_q, back_val_d;
  logic              pend_front_q, pend_front_d;
  logic              out_valid_q, out_valid_d;
  res_t              result_q, result_d;
  status_e           status_sel;
  logic              load_out;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  function automatic logic [IW-1:0] ring_next(logic [IW-1:0] idx);
    return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ring_prev(logic [IW-1:0] idx);
    return (idx == '0) ? IW'(DEPTH - 1) : idx - 1'b1;
  endfunction

  // Build a result from the state left by the operation
  function automatic res_t pack_result(status_e st, logic [CW-1:0] cnt,
                                       logic [DATA_W-1:0] fv, logic [DATA_W-1:0] bv);
    res_t              r;
    logic [CW+OCC_W-1:0] wide;
    wide          = {{OCC_W{1'b0}}, cnt};
    r.status      = st;
    r.empty_flag  = (cnt == '0);
    r.full_flag   = (cnt == CW'(DEPTH));
    r.front_value = r.empty_flag ? '0 : fv;
    r.back_value  = r.empty_flag ? '0 : bv;
    r.occupancy   = wide[OCC_W-1:0];
    return r;
  endfunction

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Execute one command
  always_comb begin
    state_d      = state_q;
    front_idx_d  = front_idx_q;
    back_idx_d   = back_idx_q;
    count_d      = count_q;
    front_val_d  = front_val_q;
    back_val_d   = back_val_q;
    pend_front_d = pend_front_q;
    out_valid_d  = out_valid_q;
    result_d     = result_q;
    status_sel   = STATUS_DONE;
    load_out     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = front_idx_q;
    ram_raddr    = front_idx_q;
    cmd_ready_o  = 1'b0;

    // Drop the held result once it is taken
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_RUN: begin
        cmd_ready_o = !out_valid_q || res_ready_i;
        if (cmd_valid_i && cmd_ready_o) begin
          load_out = 1'b1;
          if (cmd_i.is_push) begin
            if (count_q == CW'(DEPTH)) begin
              status_sel = STATUS_FULL;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + 1'b1;
              if (count_q == '0) begin
                front_idx_d = '0;
                back_idx_d  = '0;
                ram_waddr   = '0;
                front_val_d = cmd_i.value;
                back_val_d  = cmd_i.value;
              end else if (cmd_i.at_front) begin
                front_idx_d = ring_prev(front_idx_q);
                ram_waddr   = front_idx_d;
                front_val_d = cmd_i.value;
              end else begin
                back_idx_d  = ring_next(back_idx_q);
                ram_waddr   = back_idx_d;
                back_val_d  = cmd_i.value;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_sel = STATUS_EMPTY;
            end else begin
              count_d = count_q - 1'b1;
              // Entries remain: fetch the newly exposed end from the RAM
              if (count_q > CW'(1)) begin
                load_out     = 1'b0;
                ram_re       = 1'b1;
                pend_front_d = cmd_i.at_front;
                state_d      = S_READ;
                if (cmd_i.at_front) begin
                  front_idx_d = ring_next(front_idx_q);
                  ram_raddr   = front_idx_d;
                end else begin
                  back_idx_d  = ring_prev(back_idx_q);
                  ram_raddr   = back_idx_d;
                end
              end
            end
          end
          if (load_out) begin
            out_valid_d = 1'b1;
            result_d    = pack_result(status_sel, count_d, front_val_d, back_val_d);
          end
        end
      end
      S_READ: begin
        if (pend_front_q) begin
          front_val_d = ram_rdata;
        end else begin
          back_val_d = ram_rdata;
        end
        out_valid_d = 1'b1;
        result_d    = pack_result(STATUS_DONE, count_q, front_val_d, back_val_d);
        state_d     = S_RUN;
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      front_idx_q <= '0;
      back_idx_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_idx_q <= front_idx_d;
      back_idx_q  <= back_idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    front_val_q  <= front_val_d;
    back_val_q   <= back_val_d;
    pend_front_q <= pend_front_d;
    result_q     <= result_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = result_q;

endmodule

/* tb/deque_checker.sv */
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels of the deque, predicts each result from its own copy
// of the ring state and compares every result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deque_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  cdq_in_if    in_mon,
  cdq_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   result_count_o,
  output int   full_reject_o,
  output int   empty_reject_o,
  output int   peak_occupancy_o
);
  import cdq_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Predicted ring contents, ends and fill level
  logic [DATA_W-1:0] ring_entries [DEPTH];
  logic [IDX_W-1:0]  ring_front;
  logic [IDX_W-1:0]  ring_back;
  int unsigned       ring_count;

  // Results predicted but not yet seen on the output channel
  res_t expected_results [$];

  function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  // Apply one operation to the predicted deque and build the result it yields
  function automatic res_t deque_apply(kind_e op, logic [DATA_W-1:0] value);
    res_t             r;
    status_e          st;
    logic [IDX_W-1:0] slot;
    logic             no_entries;
    st = STATUS_DONE;
    if (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK) begin
      if (ring_count >= DEPTH) begin
        st = STATUS_FULL;
      end else begin
        // a push into an empty deque restarts both ends at entry zero
        if (ring_count == 0) begin
          ring_front = '0;
          ring_back  = '0;
          slot       = '0;
        end else if (op == KIND_PUSH_FRONT) begin
          ring_front = idx_prev(ring_front);
          slot       = ring_front;
        end else begin
          ring_back = idx_next(ring_back);
          slot      = ring_back;
        end
        ring_entries[slot] = value;
        ring_count++;
      end
    end else begin
      if (ring_count == 0) begin
        st = STATUS_EMPTY;
      end else begin
        // popping the last entry leaves both indices where they are
        if (ring_count > 1) begin
          if (op == KIND_POP_FRONT) ring_front = idx_next(ring_front);
          else                      ring_back  = idx_prev(ring_back);
        end
        ring_count--;
      end
    end
    no_entries    = (ring_count == 0);
    r.status      = st;
    r.front_value = no_entries ? '0 : ring_entries[ring_front];
    r.back_value  = no_entries ? '0 : ring_entries[ring_back];
    r.occupancy   = OCC_W'(ring_count);
    r.empty_flag  = no_entries;
    r.full_flag   = (ring_count >= DEPTH);
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("deque result %0d: %s expected 0x%h, got 0x%h",
             result_count_o, name, want, got);
      fail_count_o++;
    end
  endfunction

  // Compare result transfers first, then predict the request transfer
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    if (!rst_ni) begin
      ring_front       = '0;
      ring_back        = '0;
      ring_count       = 0;
      expected_results.delete();
      fail_count_o     = 0;
      pending_o        = 0;
      result_count_o   = 0;
      full_reject_o    = 0;
      empty_reject_o   = 0;
      peak_occupancy_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("deque result transfer with no request outstanding");
          fail_count_o++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("status",      DATA_W'(want.status),     DATA_W'(out_mon.status));
          check_field("front_value", want.front_value,         out_mon.front_value);
          check_field("back_value",  want.back_value,          out_mon.back_value);
          check_field("occupancy",   DATA_W'(want.occupancy),  DATA_W'(out_mon.occupancy));
          check_field("empty_flag",  DATA_W'(want.empty_flag), DATA_W'(out_mon.empty_flag));
          check_field("full_flag",   DATA_W'(want.full_flag),  DATA_W'(out_mon.full_flag));
        end
        result_count_o++;
      end
      if (in_mon.valid && in_mon.ready) begin
        want = deque_apply(kind_e'(in_mon.kind), in_mon.push_value);
        if (want.status == STATUS_FULL)  full_reject_o++;
        if (want.status == STATUS_EMPTY) empty_reject_o++;
        if (ring_count > peak_occupancy_o) peak_occupancy_o = ring_count;
        expected_results.insert(expected_results.size(), want);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the deque with a directed run over both ends, empty and full cases,
// then biased random fill and drain sequences under bursty input and a
// stalling receiver; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cdq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int          RANDOM_ITEMS = 1850;
  localparam int          DRAIN_LIMIT  = 20000;

  logic clk_i;
  logic rst_ni;

  int fail_count;
  int pending;
  int result_count;
  int full_rejects;
  int empty_rejects;
  int peak_occupancy;

  int burst_left;
  int sent_by_kind [4];

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  deque_checker #(.DEPTH(DEPTH)) deque_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .result_count_o   (result_count),
    .full_reject_o    (full_rejects),
    .empty_reject_o   (empty_rejects),
    .peak_occupancy_o (peak_occupancy)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Hard stop for a hung run
  initial begin
    #(5_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver: stall on a pattern that changes mode after a random span
  initial begin : receiver
    int mode;
    int span;
    int tick;
    out_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  // Offer one request; open a new burst with a random gap when the last ends
  task automatic send_op(kind_e op, logic [DATA_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_W'($urandom);
        in_ch.push_value <= $urandom;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= op;
    in_ch.push_value <= value;
    // hold until the transfer
    do @(posedge clk_i); while (!in_ch.ready);
    sent_by_kind[op]++;
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    burst_left = 0;
  endtask

  function automatic kind_e pick_op(int push_pct);
    logic at_back;
    at_back = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < push_pct)
      return at_back ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    return at_back ? KIND_POP_BACK : KIND_POP_FRONT;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    int seg_len;
    int push_pct;
    int waited;
    kind_e op;

    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_PUSH_FRONT;
    in_ch.push_value = '0;
    burst_left       = 0;
    foreach (sent_by_kind[k]) sent_by_kind[k] = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: pops from empty, push into empty at either end, pop the
    // last entry, fill to full and push into the full deque from both ends
    send_op(KIND_POP_FRONT,  32'h0000_0000);
    send_op(KIND_POP_BACK,   32'hFFFF_FFFF);
    send_op(KIND_PUSH_FRONT, 32'h8000_0000);
    send_op(KIND_PUSH_BACK,  32'h7FFF_FFFF);
    send_op(KIND_POP_FRONT,  32'h1234_5678);
    send_op(KIND_POP_BACK,   32'h0000_0000);
    send_op(KIND_PUSH_BACK,  32'hFFFF_FFFF);
    send_op(KIND_PUSH_FRONT, 32'h0000_0000);
    for (int i = 0; i < DEPTH - 2; i++) begin
      if (i % 2 == 0) send_op(KIND_PUSH_FRONT, 32'h5555_5555 ^ i);
      else            send_op(KIND_PUSH_BACK,  32'hAAAA_AAAA ^ i);
    end
    send_op(KIND_PUSH_FRONT, 32'hDEAD_0001);
    send_op(KIND_PUSH_BACK,  32'hDEAD_0002);
    wait_idle();

    // Random: segments biased toward filling, draining or churning
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = $urandom_range(0, 100);
      endcase
      seg_len = $urandom_range(10, 80);
      repeat (seg_len) begin
        op = pick_op(push_pct);
        send_op(op, pick_value());
        sent++;
        if (sent % 400 == 0) wait_idle();
      end
    end

    // Drain everything, then allow for the pipeline to settle
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending != 0) begin
      $display("timeout with %0d results outstanding", pending);
      $display("testbench: FAIL");
      $finish;
    end else begin
      repeat (10) @(negedge clk_i);
      $display("covered %0d push front, %0d push back, %0d pop front, %0d pop back",
               sent_by_kind[KIND_PUSH_FRONT], sent_by_kind[KIND_PUSH_BACK],
               sent_by_kind[KIND_POP_FRONT], sent_by_kind[KIND_POP_BACK]);
      $display("%0d results checked, %0d full rejects, %0d empty rejects, peak fill %0d",
               result_count, full_rejects, empty_rejects, peak_occupancy);
      if (fail_count == 0)
        $display("testbench: PASS");
      else
        $display("testbench: FAIL");
      $finish;
    end
  end

endmodule
